// ===== hw/rtl/tidc_pkg.sv =====
// Shared constants and types for the text/image display controller.
package tidc_pkg;

  localparam int TEXT_COLS  = 80;
  localparam int TEXT_ROWS  = 25;
  localparam int IMG_WIDTH  = 240;
  localparam int IMG_HEIGHT = 160;

  localparam int TEXT_CELLS = TEXT_COLS * TEXT_ROWS;
  localparam int IMG_CELLS  = IMG_WIDTH * IMG_HEIGHT;
  localparam int CLR_CELLS  = (TEXT_CELLS > IMG_CELLS) ? TEXT_CELLS : IMG_CELLS;
  localparam int SCR_CELLS  = TEXT_CELLS - TEXT_COLS;

  localparam int TEXT_AW = $clog2(TEXT_CELLS);
  localparam int IMG_AW  = $clog2(IMG_CELLS);
  localparam int CLR_W   = $clog2(CLR_CELLS);
  localparam int SCR_W   = $clog2(TEXT_CELLS + 1);

  localparam logic [2:0] KIND_SKIP  = 3'd0;
  localparam logic [2:0] KIND_MODE  = 3'd1;
  localparam logic [2:0] KIND_COLOR = 3'd2;
  localparam logic [2:0] KIND_CMD   = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] COLOR_RESET  = 8'hFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] acc;
    logic        do_move;
    logic        do_draw;
    logic        do_intr;
    logic        from_image;
    logic [15:0] raddr;
    logic        rd_oob;
  } cmd_t;

endpackage

// ===== hw/rtl/text_image_display_controller_core.sv =====
// Display controller core: text and image stores, cursor, mode, colour and mask.
//
// A command word is taken when start is high and busy is low. It executes in the
// next cycle, and its status word is registered at the end of that cycle and shown
// on the out_ ports, marked by out_valid, for one cycle; the receiver cannot stall
// it. Ordinary commands keep busy high through the execute state, so no new word
// is taken while one executes. Both stores sit in single-write memories: a mode
// set clears them one cell per cycle and holds busy until the pass ends; a text
// scroll moves the store one cell per cycle through the text memory and holds
// busy until it ends. After reset the same clearing pass runs before the first
// word is taken.
module text_image_display_controller_core
  import tidc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_acc,
  input  logic        in_do_move,
  input  logic        in_do_draw,
  input  logic        in_do_intr,
  input  logic        in_read_from_image,
  input  logic [15:0] in_read_addr,
  output logic        out_valid,
  output logic        out_skip,
  output logic        out_bounds_error,
  output logic [15:0] out_cursor_pos,
  output logic        out_image_mode,
  output logic [7:0]  out_render_color,
  output logic [7:0]  out_intr_mask,
  output logic        out_cell_written,
  output logic [15:0] out_cell_addr,
  output logic [15:0] out_cell_value
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_CLEAR  = 2'd2;
  localparam logic [1:0] S_SCROLL = 2'd3;

  logic [15:0] tx_mem [TEXT_CELLS];
  logic [15:0] im_mem [IMG_CELLS];

  logic [1:0]       st_r, st_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  logic [SCR_W-1:0] scr_r, scr_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [15:0]      cursor_r, cursor_nxt;
  logic [7:0]       col_r, col_nxt;
  logic             mode_r, mode_nxt;
  logic [7:0]       color_r, color_nxt;
  logic [7:0]       intr_r, intr_nxt;

  logic             valid_r, valid_nxt;
  logic             skip_r, skip_nxt;
  logic             berr_r, berr_nxt;
  logic             wr_r, wr_nxt;
  logic [15:0]      caddr_r, caddr_nxt;
  logic [15:0]      cval_r, cval_nxt;

  logic               tx_we, im_we;
  logic [TEXT_AW-1:0] tx_wa, tx_ra;
  logic [IMG_AW-1:0]  im_wa, im_ra;
  logic [15:0]        tx_wd, im_wd;
  logic [15:0]        tx_rd_r, im_rd_r;

  logic [7:0]  lo, hi;
  logic [15:0] txt_pos, img_pos, cur_step, draw_val, rd_val;
  logic        txt_oob, img_oob;

  assign lo       = cmd_r.acc[7:0];
  assign hi       = cmd_r.acc[15:8];
  assign txt_pos  = 16'(16'(hi) * 16'(TEXT_COLS) + 16'(lo));
  assign img_pos  = 16'(16'(hi) * 16'(IMG_WIDTH) + 16'(lo));
  assign txt_oob  = ({1'b0, lo} >= 9'(TEXT_COLS)) || ({1'b0, hi} >= 9'(TEXT_ROWS));
  assign img_oob  = ({1'b0, lo} >= 9'(IMG_WIDTH)) || ({1'b0, hi} >= 9'(IMG_HEIGHT));
  assign draw_val = {color_r, lo};
  assign rd_val   = cmd_r.rd_oob ? 16'h0000 : (cmd_r.from_image ? im_rd_r : tx_rd_r);

  always_comb begin
    st_nxt     = st_r;
    clr_nxt    = clr_r;
    scr_nxt    = scr_r;
    cmd_nxt    = cmd_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    mode_nxt   = mode_r;
    color_nxt  = color_r;
    intr_nxt   = intr_r;
    valid_nxt  = 1'b0;
    skip_nxt   = 1'b0;
    berr_nxt   = 1'b0;
    wr_nxt     = 1'b0;
    caddr_nxt  = '0;
    cval_nxt   = '0;
    tx_we      = 1'b0;
    tx_wa      = '0;
    tx_wd      = '0;
    tx_ra      = '0;
    im_we      = 1'b0;
    im_wa      = '0;
    im_wd      = '0;
    im_ra      = '0;
    cur_step   = cursor_r;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt.kind       = in_kind;
          cmd_nxt.acc        = in_acc;
          cmd_nxt.do_move    = in_do_move;
          cmd_nxt.do_draw    = in_do_draw;
          cmd_nxt.do_intr    = in_do_intr;
          cmd_nxt.from_image = in_read_from_image;
          cmd_nxt.raddr      = in_read_addr;
          cmd_nxt.rd_oob     = in_read_from_image ? (17'(in_read_addr) >= 17'(IMG_CELLS))
                                                  : (17'(in_read_addr) >= 17'(TEXT_CELLS));
          if (17'(in_read_addr) < 17'(TEXT_CELLS)) begin
            tx_ra = in_read_addr[TEXT_AW-1:0];
          end
          if (17'(in_read_addr) < 17'(IMG_CELLS)) begin
            im_ra = in_read_addr[IMG_AW-1:0];
          end
          st_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        valid_nxt = 1'b1;
        st_nxt    = S_IDLE;
        case (cmd_r.kind)
          KIND_SKIP: begin
            skip_nxt = 1'b1;
          end
          KIND_MODE: begin
            mode_nxt   = (cmd_r.acc != 16'h0000);
            cursor_nxt = '0;
            col_nxt    = '0;
            clr_nxt    = '0;
            st_nxt     = S_CLEAR;
          end
          KIND_COLOR: begin
            color_nxt = lo;
          end
          KIND_CMD: begin
            if (!mode_r) begin
              if (cmd_r.do_move) begin
                if (txt_oob) begin
                  berr_nxt = 1'b1;
                end else begin
                  cursor_nxt = txt_pos;
                  col_nxt    = lo;
                end
              end else begin
                if (cmd_r.do_draw) begin
                  if (lo == CH_NEWLINE) begin
                    cur_step = 16'(cursor_r - 16'(col_r) + 16'(TEXT_COLS));
                    col_nxt  = '0;
                  end else if (lo == CH_BACKSPACE) begin
                    if (col_r != 8'd0) begin
                      cur_step  = cursor_r - 16'd1;
                      col_nxt   = col_r - 8'd1;
                      tx_we     = 1'b1;
                      tx_wa     = cur_step[TEXT_AW-1:0];
                      tx_wd     = '0;
                      wr_nxt    = 1'b1;
                      caddr_nxt = cur_step;
                    end
                  end else begin
                    tx_we     = 1'b1;
                    tx_wa     = cursor_r[TEXT_AW-1:0];
                    tx_wd     = draw_val;
                    wr_nxt    = 1'b1;
                    caddr_nxt = cursor_r;
                    cval_nxt  = draw_val;
                    cur_step  = cursor_r + 16'd1;
                    col_nxt   = (col_r == 8'(TEXT_COLS - 1)) ? 8'd0 : col_r + 8'd1;
                  end
                  if (17'(cur_step) >= 17'(TEXT_CELLS)) begin
                    cursor_nxt = 16'(cur_step - 16'(TEXT_COLS));
                    scr_nxt    = '0;
                    st_nxt     = S_SCROLL;
                  end else begin
                    cursor_nxt = cur_step;
                  end
                end
                if (cmd_r.do_intr) begin
                  intr_nxt = lo;
                end
              end
            end else begin
              if (cmd_r.do_move && img_oob) begin
                berr_nxt = 1'b1;
              end else begin
                if (cmd_r.do_move) begin
                  cur_step = img_pos;
                end
                cursor_nxt = cur_step;
                if (cmd_r.do_draw) begin
                  im_we      = 1'b1;
                  im_wa      = cur_step[IMG_AW-1:0];
                  im_wd      = draw_val;
                  wr_nxt     = 1'b1;
                  caddr_nxt  = cur_step;
                  cval_nxt   = draw_val;
                  cursor_nxt = (17'(cur_step) + 17'd1 >= 17'(IMG_CELLS)) ? 16'd0
                                                                         : cur_step + 16'd1;
                end
                if (cmd_r.do_intr) begin
                  intr_nxt = lo;
                end
              end
            end
          end
          KIND_READ: begin
            caddr_nxt = cmd_r.raddr;
            cval_nxt  = rd_val;
          end
          default: begin
          end
        endcase
      end

      S_CLEAR: begin
        if (32'(clr_r) < TEXT_CELLS) begin
          tx_we = 1'b1;
          tx_wa = TEXT_AW'(clr_r);
        end
        if (32'(clr_r) < IMG_CELLS) begin
          im_we = 1'b1;
          im_wa = IMG_AW'(clr_r);
        end
        if (32'(clr_r) == CLR_CELLS - 1) begin
          st_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_SCROLL: begin
        if (32'(scr_r) < SCR_CELLS) begin
          tx_ra = TEXT_AW'(32'(scr_r) + TEXT_COLS);
        end
        if (scr_r != '0) begin
          tx_we = 1'b1;
          tx_wa = TEXT_AW'(scr_r - 1'b1);
          tx_wd = (32'(scr_r) <= SCR_CELLS) ? tx_rd_r : 16'h0000;
        end
        if (32'(scr_r) == TEXT_CELLS) begin
          st_nxt = S_IDLE;
        end else begin
          scr_nxt = scr_r + 1'b1;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wa] <= tx_wd;
    end
    tx_rd_r <= tx_mem[tx_ra];
  end

  always_ff @(posedge clk) begin
    if (im_we) begin
      im_mem[im_wa] <= im_wd;
    end
    im_rd_r <= im_mem[im_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLEAR;
      clr_r    <= '0;
      scr_r    <= '0;
      cursor_r <= '0;
      col_r    <= '0;
      mode_r   <= 1'b0;
      color_r  <= COLOR_RESET;
      intr_r   <= '0;
      valid_r  <= 1'b0;
      skip_r   <= 1'b0;
      berr_r   <= 1'b0;
      wr_r     <= 1'b0;
      caddr_r  <= '0;
      cval_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      scr_r    <= scr_nxt;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      mode_r   <= mode_nxt;
      color_r  <= color_nxt;
      intr_r   <= intr_nxt;
      valid_r  <= valid_nxt;
      skip_r   <= skip_nxt;
      berr_r   <= berr_nxt;
      wr_r     <= wr_nxt;
      caddr_r  <= caddr_nxt;
      cval_r   <= cval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign busy             = (st_r != S_IDLE);
  assign out_valid        = valid_r;
  assign out_skip         = skip_r;
  assign out_bounds_error = berr_r;
  assign out_cursor_pos   = cursor_r;
  assign out_image_mode   = mode_r;
  assign out_render_color = color_r;
  assign out_intr_mask    = intr_r;
  assign out_cell_written = wr_r;
  assign out_cell_addr    = caddr_r;
  assign out_cell_value   = cval_r;

  // result word only ever follows an execute cycle
  a_valid_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(st_r == S_EXEC))
    else $error("status word without execute cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && st_r == S_EXEC))
    else $error("accepted word did not enter execute");

  a_text_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && !mode_r) |-> (17'(cursor_r) < 17'(TEXT_CELLS)))
    else $error("text cursor beyond store");

  a_scroll_text: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCROLL) |-> !mode_r)
    else $error("scroll in image mode");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the text/image display controller core.
module tb;
  import tidc_pkg::*;

  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] acc;
    logic        do_move;
    logic        do_draw;
    logic        do_intr;
    logic        from_image;
    logic [15:0] raddr;
  } display_cmd_t;

  typedef struct packed {
    logic        skip;
    logic        bounds_error;
    logic [15:0] cursor_pos;
    logic        image_mode;
    logic [7:0]  render_color;
    logic [7:0]  intr_mask;
    logic        cell_written;
    logic [15:0] cell_addr;
    logic [15:0] cell_value;
  } status_word_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [15:0] in_acc;
  logic        in_do_move;
  logic        in_do_draw;
  logic        in_do_intr;
  logic        in_read_from_image;
  logic [15:0] in_read_addr;
  logic        out_valid;
  logic        out_skip;
  logic        out_bounds_error;
  logic [15:0] out_cursor_pos;
  logic        out_image_mode;
  logic [7:0]  out_render_color;
  logic [7:0]  out_intr_mask;
  logic        out_cell_written;
  logic [15:0] out_cell_addr;
  logic [15:0] out_cell_value;

  text_image_display_controller_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_acc             (in_acc),
    .in_do_move         (in_do_move),
    .in_do_draw         (in_do_draw),
    .in_do_intr         (in_do_intr),
    .in_read_from_image (in_read_from_image),
    .in_read_addr       (in_read_addr),
    .out_valid          (out_valid),
    .out_skip           (out_skip),
    .out_bounds_error   (out_bounds_error),
    .out_cursor_pos     (out_cursor_pos),
    .out_image_mode     (out_image_mode),
    .out_render_color   (out_render_color),
    .out_intr_mask      (out_intr_mask),
    .out_cell_written   (out_cell_written),
    .out_cell_addr      (out_cell_addr),
    .out_cell_value     (out_cell_value)
  );

  logic [15:0]  text_store [TEXT_CELLS];
  logic [15:0]  image_store [IMG_CELLS];
  int unsigned  cursor_m;
  logic         image_mode_m;
  logic [7:0]   color_m;
  logic [7:0]   intr_m;
  status_word_t pending_status_q[$];
  int           mismatches;
  int           idle_cycles;
  int           scroll_budget;
  int           mode_set_budget;
  bit           no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_stores();
    foreach (text_store[i]) text_store[i] = 16'h0;
    foreach (image_store[i]) image_store[i] = 16'h0;
  endfunction

  function automatic status_word_t display_step(display_cmd_t w);
    status_word_t s;
    logic [7:0]   lo;
    logic [7:0]   hi;
    logic [15:0]  v;
    bit           go_on;
    int           i;
    s = '0;
    lo = w.acc[7:0];
    hi = w.acc[15:8];
    v = {color_m, lo};
    go_on = 1'b1;
    case (w.kind)
      KIND_SKIP: s.skip = 1'b1;
      KIND_MODE: begin
        image_mode_m = (w.acc != 16'h0);
        clear_stores();
        cursor_m = 0;
      end
      KIND_COLOR: color_m = lo;
      KIND_CMD: begin
        if (w.do_move) begin
          if (!image_mode_m) begin
            if (lo >= TEXT_COLS || hi >= TEXT_ROWS) s.bounds_error = 1'b1;
            else cursor_m = hi * TEXT_COLS + lo;
            go_on = 1'b0;
          end else if (lo >= IMG_WIDTH || hi >= IMG_HEIGHT) begin
            s.bounds_error = 1'b1;
            go_on = 1'b0;
          end else begin
            cursor_m = hi * IMG_WIDTH + lo;
          end
        end
        if (go_on && w.do_draw) begin
          if (!image_mode_m) begin
            if (lo == CH_NEWLINE) begin
              cursor_m = (cursor_m / TEXT_COLS + 1) * TEXT_COLS;
            end else if (lo == CH_BACKSPACE) begin
              if (cursor_m % TEXT_COLS != 0 && cursor_m <= TEXT_CELLS) begin
                cursor_m = cursor_m - 1;
                text_store[cursor_m] = 16'h0;
                s.cell_written = 1'b1;
                s.cell_addr = cursor_m[15:0];
              end
            end else if (cursor_m < TEXT_CELLS) begin
              text_store[cursor_m] = v;
              s.cell_written = 1'b1;
              s.cell_addr = cursor_m[15:0];
              s.cell_value = v;
              cursor_m = cursor_m + 1;
            end
            if (cursor_m >= TEXT_CELLS) begin
              for (i = 0; i < SCR_CELLS; i++) text_store[i] = text_store[i + TEXT_COLS];
              for (i = SCR_CELLS; i < TEXT_CELLS; i++) text_store[i] = 16'h0;
              cursor_m = cursor_m - TEXT_COLS;
            end
          end else begin
            if (cursor_m < IMG_CELLS) begin
              image_store[cursor_m] = v;
              s.cell_written = 1'b1;
              s.cell_addr = cursor_m[15:0];
              s.cell_value = v;
            end
            cursor_m = cursor_m + 1;
            if (cursor_m >= IMG_CELLS) cursor_m = 0;
          end
        end
        if (go_on && w.do_intr) intr_m = lo;
      end
      KIND_READ: begin
        s.cell_addr = w.raddr;
        if (w.from_image) s.cell_value = (w.raddr < IMG_CELLS) ? image_store[w.raddr] : 16'h0;
        else s.cell_value = (w.raddr < TEXT_CELLS) ? text_store[w.raddr] : 16'h0;
      end
      default: ;
    endcase
    s.cursor_pos = cursor_m[15:0];
    s.image_mode = image_mode_m;
    s.render_color = color_m;
    s.intr_mask = intr_m;
    return s;
  endfunction

  // true when the word would push the text cursor past the last cell
  function automatic bit scrolls_text(display_cmd_t w);
    if (image_mode_m || w.kind != KIND_CMD || !w.do_draw || w.do_move) return 1'b0;
    if (w.acc[7:0] == CH_NEWLINE) return cursor_m >= SCR_CELLS;
    return w.acc[7:0] != CH_BACKSPACE && cursor_m == TEXT_CELLS - 1;
  endfunction

  function automatic display_cmd_t cmd_word(logic [2:0] kind, logic [15:0] acc,
                                            logic mv, logic dr, logic it,
                                            logic img, logic [15:0] addr);
    display_cmd_t w;
    w.kind = kind;
    w.acc = acc;
    w.do_move = mv;
    w.do_draw = dr;
    w.do_intr = it;
    w.from_image = img;
    w.raddr = addr;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] legal_position();
    logic [7:0] x;
    logic [7:0] y;
    if (!image_mode_m) begin
      x = 8'($urandom_range(0, TEXT_COLS - 1));
      y = 8'($urandom_range(0, TEXT_ROWS - 1));
    end else if ($urandom_range(0, 9) == 0) begin
      x = 8'($urandom_range(IMG_WIDTH - 10, IMG_WIDTH - 1));
      y = 8'(IMG_HEIGHT - 1);
    end else begin
      x = 8'($urandom_range(0, IMG_WIDTH - 1));
      y = 8'($urandom_range(0, IMG_HEIGHT - 1));
    end
    return {y, x};
  endfunction

  function automatic display_cmd_t random_cmd();
    display_cmd_t w;
    int           r;
    int           sel;
    logic [7:0]   x;
    logic [7:0]   y;
    w = cmd_word(KIND_CMD, 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                 1'($urandom), 16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 20) begin
      w.kind = KIND_READ;
      w.from_image = ($urandom_range(0, 4) == 0) ? !image_mode_m : image_mode_m;
      sel = $urandom_range(0, 9);
      if (sel < 5)
        w.raddr = (cursor_m > 100) ? 16'(cursor_m - $urandom_range(0, 100)) :
                                     16'($urandom_range(0, cursor_m));
      else if (sel < 8)
        w.raddr = 16'($urandom_range(0, (w.from_image ? IMG_CELLS : TEXT_CELLS) - 1));
    end else if (r < 28) begin
      w.kind = KIND_COLOR;
    end else if (r < 34) begin
      w.kind = KIND_SKIP;
    end else if (r < 37) begin
      w.kind = 3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
    end else if (r == 99 && mode_set_budget > 0 && $urandom_range(0, 3) == 0) begin
      w.kind = KIND_MODE;
      if ($urandom_range(0, 1) == 0) w.acc = 16'h0;
      mode_set_budget--;
    end else begin
      w.do_move = ($urandom_range(0, 99) < 25);
      w.do_draw = ($urandom_range(0, 99) < 85);
      w.do_intr = ($urandom_range(0, 99) < 25);
      if (w.do_move && $urandom_range(0, 9) != 0) begin
        w.acc = legal_position();
      end else if (w.do_draw && !image_mode_m) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) w.acc[7:0] = CH_NEWLINE;
        else if (sel == 1) w.acc[7:0] = CH_BACKSPACE;
      end
    end
    // each scroll stalls for a full pass over the text store, so ration them
    if (scrolls_text(w)) begin
      if (scroll_budget > 0) begin
        scroll_budget--;
      end else begin
        x = 8'($urandom_range(0, TEXT_COLS - 1));
        y = 8'($urandom_range(0, TEXT_ROWS - 2));
        w.do_move = 1'b1;
        w.acc = {y, x};
      end
    end
    return w;
  endfunction

  task automatic send_word(input display_cmd_t w);
    int gap;
    start <= 1'b1;
    in_kind <= w.kind;
    in_acc <= w.acc;
    in_do_move <= w.do_move;
    in_do_draw <= w.do_draw;
    in_do_intr <= w.do_intr;
    in_read_from_image <= w.from_image;
    in_read_addr <= w.raddr;
    do @(posedge clk); while (busy);
    pending_status_q.push_back(display_step(w));
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      in_kind <= 3'($urandom);
      in_acc <= 16'($urandom);
      in_do_move <= 1'($urandom);
      in_do_draw <= 1'($urandom);
      in_do_intr <= 1'($urandom);
      in_read_from_image <= 1'($urandom);
      in_read_addr <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_status_words();
    send_word(cmd_word(KIND_SKIP, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    send_word(cmd_word(KIND_COLOR, 16'hFF00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'h00FF, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0));
    send_word(cmd_word(KIND_RSVD_FIRST, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0));
    send_word(cmd_word(KIND_RSVD_LAST, 16'h1234, 1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF));
    send_word(cmd_word(KIND_COLOR, 16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0));
  endtask

  task automatic test_text_drawing();
    send_word(cmd_word(KIND_CMD, 16'h0041, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, {8'h00, CH_BACKSPACE}, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, {8'h00, CH_BACKSPACE}, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
    // move ends the command in text mode: no draw, no mask load
    send_word(cmd_word(KIND_CMD, 16'h184F, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'h0050, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'h1900, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'h005A, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'h1705, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, {8'h00, CH_NEWLINE}, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, {8'h00, CH_NEWLINE}, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_READ, 16'h0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1839));
    send_word(cmd_word(KIND_READ, 16'h0, 1'b0, 1'b0, 1'b0, 1'b0, 16'(TEXT_CELLS)));
    send_word(cmd_word(KIND_READ, 16'h0, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF));
  endtask

  task automatic test_image_drawing();
    send_word(cmd_word(KIND_MODE, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'h9FEF, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'h00F0, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, 16'hA000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_CMD, {8'h00, CH_NEWLINE}, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_READ, 16'h0, 1'b0, 1'b0, 1'b0, 1'b1, 16'(IMG_CELLS - 1)));
    send_word(cmd_word(KIND_READ, 16'h0, 1'b0, 1'b0, 1'b0, 1'b1, 16'(IMG_CELLS)));
  endtask

  task automatic test_mode_clear();
    send_word(cmd_word(KIND_MODE, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0));
    send_word(cmd_word(KIND_READ, 16'h0, 1'b0, 1'b0, 1'b0, 1'b1, 16'(IMG_CELLS - 1)));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_word(random_cmd());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_text();
    test_random_traffic(900);
  endtask

  task automatic test_random_image();
    send_word(cmd_word(KIND_MODE, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0));
    test_random_traffic(850);
  endtask

  always @(posedge clk) begin
    status_word_t exp_s;
    status_word_t got_s;
    if (rst_n && out_valid) begin
      got_s = '{out_skip, out_bounds_error, out_cursor_pos, out_image_mode,
                out_render_color, out_intr_mask, out_cell_written, out_cell_addr,
                out_cell_value};
      if (pending_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected status word %h", got_s);
      end else begin
        exp_s = pending_status_q.pop_front();
        if (got_s !== exp_s) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("exp: sk=%0d be=%0d cur=%0d im=%0d col=%h msk=%h wr=%0d ad=%0d va=%h",
                     exp_s.skip, exp_s.bounds_error, exp_s.cursor_pos, exp_s.image_mode,
                     exp_s.render_color, exp_s.intr_mask, exp_s.cell_written,
                     exp_s.cell_addr, exp_s.cell_value);
            $display("got: sk=%0d be=%0d cur=%0d im=%0d col=%h msk=%h wr=%0d ad=%0d va=%h",
                     got_s.skip, got_s.bounds_error, got_s.cursor_pos, got_s.image_mode,
                     got_s.render_color, got_s.intr_mask, got_s.cell_written,
                     got_s.cell_addr, got_s.cell_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    scroll_budget = 40;
    mode_set_budget = 3;
    no_idle = 1'b0;
    clear_stores();
    cursor_m = 0;
    image_mode_m = 1'b0;
    color_m = COLOR_RESET;
    intr_m = 8'h0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_SKIP;
    in_acc <= 16'h0;
    in_do_move <= 1'b0;
    in_do_draw <= 1'b0;
    in_do_intr <= 1'b0;
    in_read_from_image <= 1'b0;
    in_read_addr <= 16'h0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_status_words();
    test_text_drawing();
    test_image_drawing();
    test_mode_clear();
    wait_idle();
    test_random_text();
    wait_idle();
    test_random_image();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_status_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tidc_pkg.sv
hw/rtl/text_image_display_controller_core.sv
test/tb.sv
